FILE: rtl/scba_pkg.sv
// Package for the size-class block allocator: geometry constants, status codes,
// beat structs and the class geometry helper functions.
// No dependencies; scba_decode and the allocator core use it by scoped names.
package scba_pkg;

   // Geometry of the pool.
   localparam int REGION_BYTES = 65536;
   localparam int CLASS_COUNT  = 9;
   localparam int ROUND_BYTES  = 8;
   localparam int MIN_BLOCK    = 16;
   localparam int MIN_LOG2     = 4;

   // Field widths fixed by the interface.
   localparam int KIND_W   = 1;
   localparam int REQ_W    = 16;
   localparam int ADDR_W   = 20;
   localparam int STATUS_W = 3;
   localparam int CLASS_W  = 4;
   localparam int BYTES_W  = 13;
   localparam int USED_W   = 20;
   localparam int LIVE_W   = 13;

   // Derived widths.
   localparam int REGION_LOG2 = $clog2(REGION_BYTES);
   localparam int BLOCKS_MAX  = REGION_BYTES / MIN_BLOCK;
   localparam int IDX_W       = $clog2(BLOCKS_MAX);
   localparam int DEPTH_W     = $clog2(BLOCKS_MAX + 1);
   localparam int STORE_DEPTH = (REGION_BYTES / 8) - (REGION_BYTES / (8 << CLASS_COUNT));
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int CIDX_W      = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
   localparam int ROUND_W     = REQ_W + 1;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_ZERO      = 3'd1,
      ST_TOO_LARGE = 3'd2,
      ST_EXHAUSTED = 3'd3,
      ST_BAD_ADDR  = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   // Request beat.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [REQ_W-1:0]  request_bytes;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   // Response beat.
   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  block_address;
      logic [CLASS_W-1:0] size_class;
      logic [BYTES_W-1:0] granted_bytes;
      logic [USED_W-1:0]  bytes_in_use;
      logic [LIVE_W-1:0]  live_count;
   } rsp_type;

   // Decoded request handed from the decoder to the stack control.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      status_type         status;
      logic [CLASS_W-1:0] cls;
      logic [IDX_W-1:0]   idx;
      logic [BYTES_W-1:0] bs;
   } dec_type;

   // Block size of a class.
   function automatic logic [BYTES_W-1:0] block_bytes(input logic [CLASS_W-1:0] c);
      return BYTES_W'(MIN_BLOCK << c);
   endfunction

   // Number of blocks in a class region.
   function automatic logic [DEPTH_W-1:0] block_count(input logic [CLASS_W-1:0] c);
      return DEPTH_W'(REGION_BYTES >> (MIN_LOG2 + c));
   endfunction

   // First store slot of a class segment: the segment sizes halve per class.
   function automatic logic [STORE_AW-1:0] seg_base(input logic [CLASS_W-1:0] c);
      return STORE_AW'((REGION_BYTES >> 3) - (REGION_BYTES >> (3 + c)));
   endfunction

endpackage

FILE: rtl/scba_stack_ram.sv
// Single-port synchronous RAM for the free index stacks.
// One access per cycle, registered read data that holds between reads.
// Generic; no package dependency.
module scba_stack_ram #(
   parameter int DEPTH = 8176,
   parameter int AW    = 13,
   parameter int DW    = 12
) (
   input  logic          clock,
   input  logic          we,
   input  logic          re,
   input  logic [AW-1:0] addr,
   input  logic [DW-1:0] wdata,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [0:DEPTH-1];
   logic [DW-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/scba_decode.sv
// Request decoder: size class selection for allocations, class and block
// index extraction for frees, and the request-level error checks.
// Depends on scba_pkg.
module scba_decode (
   input  scba_pkg::req_type req,
   output scba_pkg::dec_type dec
);

   logic [scba_pkg::ROUND_W-1:0]     rounded;
   logic                             found;
   logic [scba_pkg::CLASS_W-1:0]     pick;
   logic [scba_pkg::ADDR_W-1:0]      region_sel;
   logic [scba_pkg::CLASS_W-1:0]     fcls;
   logic [scba_pkg::REGION_LOG2-1:0] offset;
   logic [scba_pkg::REGION_LOG2-1:0] idx_full;

   always_comb begin
      // Round up to the allocation granule.
      rounded = scba_pkg::ROUND_W'(((scba_pkg::ROUND_W'(req.request_bytes)
                + scba_pkg::ROUND_W'(scba_pkg::ROUND_BYTES - 1)) / scba_pkg::ROUND_BYTES)
                * scba_pkg::ROUND_BYTES);

      // Smallest class that fits; the compares are independent.
      found = 1'b0;
      pick  = '0;
      for (int c = scba_pkg::CLASS_COUNT - 1; c >= 0; c--) begin
         if (rounded <= scba_pkg::ROUND_W'(scba_pkg::block_bytes(scba_pkg::CLASS_W'(c)))) begin
            found = 1'b1;
            pick  = scba_pkg::CLASS_W'(c);
         end
      end

      // Address fields for a free.
      region_sel = req.free_address >> scba_pkg::REGION_LOG2;
      fcls       = scba_pkg::CLASS_W'(region_sel);
      offset     = req.free_address[scba_pkg::REGION_LOG2-1:0];
      idx_full   = offset >> (scba_pkg::MIN_LOG2 + fcls);

      dec.kind = req.kind;
      dec.cls  = '0;
      dec.idx  = '0;
      dec.bs   = '0;
      if (req.kind == scba_pkg::KIND_ALLOC) begin
         if (req.request_bytes == '0) begin
            dec.status = scba_pkg::ST_ZERO;
         end else if (!found) begin
            dec.status = scba_pkg::ST_TOO_LARGE;
         end else begin
            dec.status = scba_pkg::ST_OK;
            dec.cls    = pick;
            dec.bs     = scba_pkg::block_bytes(pick);
         end
      end else begin
         if (region_sel >= scba_pkg::ADDR_W'(scba_pkg::CLASS_COUNT)) begin
            dec.status = scba_pkg::ST_BAD_ADDR;
         end else if (scba_pkg::DEPTH_W'(idx_full) >= scba_pkg::block_count(fcls)) begin
            dec.status = scba_pkg::ST_BAD_ADDR;
         end else begin
            dec.status = scba_pkg::ST_OK;
            dec.cls    = fcls;
            dec.idx    = scba_pkg::IDX_W'(idx_full);
            dec.bs     = scba_pkg::block_bytes(fcls);
         end
      end
   end

endmodule

FILE: rtl/size_class_block_allocator_core.sv
// Size-class block allocator. In the accept cycle of a request beat the
// per-class stack depth is checked and updated, the counters are updated and
// the single-port index RAM is either read (allocate) or written (free); in
// the response stage the registered RAM data forms the block address and the
// response beat is loaded into the output register once that register is
// empty or not stalled. Only one beat is held in flight, so no new request
// is taken until its response is loaded, and a stalled response side holds
// the beat back. No clearing pass runs after reset: a per-class low-water
// mark tells which stack slots are still unwritten, so requests are taken
// right after reset.
// Depends on scba_pkg, scba_decode and scba_stack_ram.
module size_class_block_allocator_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  scba_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output scba_pkg::rsp_type rsp_data
);

   scba_pkg::dec_type dec;

   // Per-class stack depth and low-water mark.
   logic [scba_pkg::DEPTH_W-1:0] depth_ff [0:scba_pkg::CLASS_COUNT-1];
   logic [scba_pkg::DEPTH_W-1:0] depth_in [0:scba_pkg::CLASS_COUNT-1];
   logic [scba_pkg::DEPTH_W-1:0] lw_ff    [0:scba_pkg::CLASS_COUNT-1];
   logic [scba_pkg::DEPTH_W-1:0] lw_in    [0:scba_pkg::CLASS_COUNT-1];

   logic [scba_pkg::USED_W-1:0] used_ff, used_in;
   logic [scba_pkg::LIVE_W-1:0] live_ff, live_in;

   // Item in flight between accept and response load.
   logic                          busy_ff, busy_in;
   scba_pkg::status_type          st_ff, st_in;
   logic [scba_pkg::CLASS_W-1:0]  cls_ff, cls_in;
   logic [scba_pkg::BYTES_W-1:0]  gb_ff, gb_in;
   logic                          pop_ff, pop_in;
   logic                          lw_hit_ff, lw_hit_in;
   logic [scba_pkg::IDX_W-1:0]    fb_idx_ff, fb_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   scba_pkg::rsp_type rsp_ff, rsp_in;

   logic                          accept;
   logic                          load;
   logic [scba_pkg::CIDX_W-1:0]   cidx;
   logic [scba_pkg::DEPTH_W-1:0]  depth_cur;
   logic [scba_pkg::DEPTH_W-1:0]  depth_dec;
   logic [scba_pkg::DEPTH_W-1:0]  lw_cur;
   logic [scba_pkg::DEPTH_W-1:0]  count_cur;
   logic                          dec_ok;
   logic                          pop_ok, push_ok;
   logic                          ram_we, ram_re;
   logic [scba_pkg::STORE_AW-1:0] ram_addr;
   logic [scba_pkg::IDX_W-1:0]    ram_rdata;
   logic [scba_pkg::USED_W:0]     used_sum;
   logic [scba_pkg::IDX_W-1:0]    idx_sel;
   logic [scba_pkg::ADDR_W-1:0]   addr_calc;

   scba_decode u_decode (
      .req (req_data),
      .dec (dec)
   );

   scba_stack_ram #(
      .DEPTH (scba_pkg::STORE_DEPTH),
      .AW    (scba_pkg::STORE_AW),
      .DW    (scba_pkg::IDX_W)
   ) u_stack_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (dec.idx),
      .rdata (ram_rdata)
   );

   // Handshakes: one beat in flight, response held in its own register.
   assign accept    = req_valid && !req_stall;
   assign req_stall = busy_ff;
   assign load      = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Accept cycle: stack checks, depth and counter updates, RAM access.
   always_comb begin
      dec_ok    = (dec.status == scba_pkg::ST_OK);
      cidx      = scba_pkg::CIDX_W'(dec.cls);
      depth_cur = dec_ok ? depth_ff[cidx] : '0;
      lw_cur    = dec_ok ? lw_ff[cidx] : '0;
      count_cur = scba_pkg::block_count(dec.cls);
      depth_dec = depth_cur - scba_pkg::DEPTH_W'(1);

      pop_ok  = accept && dec_ok && (dec.kind == scba_pkg::KIND_ALLOC)
                && (depth_cur != '0);
      push_ok = accept && dec_ok && (dec.kind == scba_pkg::KIND_FREE)
                && (depth_cur < count_cur);

      ram_we   = push_ok;
      ram_re   = pop_ok;
      ram_addr = scba_pkg::seg_base(dec.cls)
                 + scba_pkg::STORE_AW'(pop_ok ? depth_dec : depth_cur);

      // Status of this request.
      if (!dec_ok) begin
         st_in = dec.status;
      end else if (dec.kind == scba_pkg::KIND_ALLOC) begin
         st_in = (depth_cur == '0) ? scba_pkg::ST_EXHAUSTED : scba_pkg::ST_OK;
      end else begin
         st_in = (depth_cur >= count_cur) ? scba_pkg::ST_FULL : scba_pkg::ST_OK;
      end

      for (int c = 0; c < scba_pkg::CLASS_COUNT; c++) begin
         depth_in[c] = depth_ff[c];
         lw_in[c]    = lw_ff[c];
      end
      used_in  = used_ff;
      live_in  = live_ff;
      used_sum = {1'b0, used_ff} + (scba_pkg::USED_W + 1)'(dec.bs);

      if (pop_ok) begin
         depth_in[cidx] = depth_dec;
         if (depth_dec < lw_cur) begin
            lw_in[cidx] = depth_dec;
         end
         used_in = used_sum[scba_pkg::USED_W] ? '1 : used_sum[scba_pkg::USED_W-1:0];
         if (live_ff != '1) begin
            live_in = live_ff + scba_pkg::LIVE_W'(1);
         end
      end else if (push_ok) begin
         depth_in[cidx] = depth_cur + scba_pkg::DEPTH_W'(1);
         used_in = (used_ff >= scba_pkg::USED_W'(dec.bs))
                   ? used_ff - scba_pkg::USED_W'(dec.bs) : '0;
         if (live_ff != '0) begin
            live_in = live_ff - scba_pkg::LIVE_W'(1);
         end
      end

      // Slots below the low-water mark were never written; their index is the slot position.
      lw_hit_in = (depth_dec < lw_cur);
      fb_idx_in = scba_pkg::IDX_W'(depth_dec);
      pop_in    = pop_ok;
      cls_in    = (st_in == scba_pkg::ST_OK || st_in == scba_pkg::ST_EXHAUSTED
                   || st_in == scba_pkg::ST_FULL) ? dec.cls : '0;
      gb_in     = (st_in == scba_pkg::ST_OK) ? dec.bs : '0;

      busy_in = accept ? 1'b1 : (load ? 1'b0 : busy_ff);
   end

   // Response cycle: block address from the popped index.
   always_comb begin
      idx_sel   = lw_hit_ff ? fb_idx_ff : ram_rdata;
      addr_calc = (scba_pkg::ADDR_W'(cls_ff) << scba_pkg::REGION_LOG2)
                  + (scba_pkg::ADDR_W'(idx_sel) << (scba_pkg::MIN_LOG2 + cls_ff));

      rsp_in.status        = st_ff;
      rsp_in.block_address = pop_ff ? addr_calc : '0;
      rsp_in.size_class    = cls_ff;
      rsp_in.granted_bytes = gb_ff;
      rsp_in.bytes_in_use  = used_ff;
      rsp_in.live_count    = live_ff;

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state and per-class stack state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         live_ff      <= '0;
         for (int c = 0; c < scba_pkg::CLASS_COUNT; c++) begin
            depth_ff[c] <= scba_pkg::block_count(scba_pkg::CLASS_W'(c));
            lw_ff[c]    <= scba_pkg::block_count(scba_pkg::CLASS_W'(c));
         end
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         live_ff      <= live_in;
         for (int c = 0; c < scba_pkg::CLASS_COUNT; c++) begin
            depth_ff[c] <= depth_in[c];
            lw_ff[c]    <= lw_in[c];
         end
      end
   end

   // Payload of the beat in flight and of the response register.
   always_ff @(posedge clock) begin
      if (accept) begin
         st_ff     <= st_in;
         cls_ff    <= cls_in;
         gb_ff     <= gb_in;
         pop_ff    <= pop_in;
         lw_hit_ff <= lw_hit_in;
         fb_idx_ff <= fb_idx_in;
      end
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // An accepted beat always occupies the response stage next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted beat did not enter the response stage");

   // Failed requests never report granted bytes or an address.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != scba_pkg::ST_OK)
      |-> (rsp_ff.granted_bytes == '0) && (rsp_ff.block_address == '0))
      else $error("failed response carries a grant");

   // A granted address lies in the region of the reported class.
   a_addr_region: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == scba_pkg::ST_OK) && (rsp_ff.block_address != '0)
      |-> ((rsp_ff.block_address >> scba_pkg::REGION_LOG2)
           == scba_pkg::ADDR_W'(rsp_ff.size_class)))
      else $error("block address outside its class region");

   // The depth of the smallest class never exceeds its block count.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff[0] <= scba_pkg::block_count('0))
      else $error("stack depth above class capacity");

endmodule
